// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// expects a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define AST_RUN(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define AST_ALL(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define AST_RUN(label, prop, msg)

`define AST_ALL(label, prop, msg)

`endif

`endif

// ===== rtl/rme_pkg.sv =====
// shared types and constants for the modular exponentiation block
// no dependencies
package rme_pkg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_status;

    localparam logic [1:0] REG_MODULUS = 2'd0;
    localparam logic [1:0] REG_ENC_EXP = 2'd1;
    localparam logic [1:0] REG_DEC_EXP = 2'd2;

    localparam logic REQ_DECRYPT = 1'b1;

endpackage

// ===== rtl/rsa_modular_exponentiation.sv =====
// top level: computes value^e or value^d mod n with one shared serial multiplier
// depends on rme_pkg, rme_cfg, rme_modmul and assert_macros.svh
//
// input channel: i_in_valid / o_in_ready carry one word (i_req_type, i_message_value).
// req_type 0 raises the value to the encryption exponent, 1 to the decryption exponent.
// output channel: o_out_valid / i_out_ready carry o_result_value, one word per input.
// configuration: apb port, modulus at 0x0, enc exponent at 0x4, dec exponent at 0x8
// (8-byte spacing when WIDTH is above 32); write only while the block is idle.
// each modular multiply is a load, WIDTH shift-add-reduce steps and a hand-off.
// one word costs a reduction of the value, then for each exponent bit up to the top
// set bit a squaring plus a multiply where the bit is set; the block is ready for a
// new word in the same cycle that the result appears.
// a modulus below two returns 0; a zero exponent returns 1.
// o_in_ready is high only while no word is being worked on; a finished result waits
// in the output register while a new word is taken, and the sequencer holds its next
// result until the receiver takes the previous one.
// reset (synchronous, active low) restores modulus 2 and both exponents 1 and
// drops all pending words.
module rsa_modular_exponentiation #(
    parameter int WIDTH = 32,
    localparam int PDW = (WIDTH > 32) ? 64 : 32,
    localparam int ASH = (WIDTH > 32) ? 3 : 2,
    localparam int AW  = ASH + 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_req_type,
    input  logic [WIDTH-1:0] i_message_value,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [WIDTH-1:0] o_result_value,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AW-1:0]    paddr,
    input  logic [PDW-1:0]   pwdata,
    output logic [PDW-1:0]   prdata,
    output logic             pready
);
    import rme_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED,
        S_STEP,
        S_MACC,
        S_MSQ,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [WIDTH-1:0] r_n;
    logic [WIDTH-1:0] r_exp;
    logic [WIDTH-1:0] r_base;
    logic [WIDTH-1:0] r_acc;
    logic             r_mm_start;
    logic [WIDTH-1:0] r_mm_a;
    logic [WIDTH-1:0] r_mm_b;
    logic             r_out_valid;
    logic [WIDTH-1:0] r_result;

    logic [WIDTH-1:0] cfg_modulus;
    logic [WIDTH-1:0] cfg_enc_exp;
    logic [WIDTH-1:0] cfg_dec_exp;
    t_mm_status       mm_status;
    logic [WIDTH-1:0] mm_result;
    logic             in_acc;
    logic             out_free;

    rme_cfg #(
        .WIDTH (WIDTH),
        .PDW   (PDW),
        .ASH   (ASH),
        .AW    (AW)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .o_modulus (cfg_modulus),
        .o_enc_exp (cfg_enc_exp),
        .o_dec_exp (cfg_dec_exp)
    );

    rme_modmul #(
        .WIDTH (WIDTH)
    ) u_modmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_mm_start),
        .i_a      (r_mm_a),
        .i_b      (r_mm_b),
        .i_n      (r_n),
        .o_status (mm_status),
        .o_result (mm_result)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid & o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mm_start  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_mm_start <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_n   <= cfg_modulus;
                        r_exp <= (i_req_type == REQ_DECRYPT) ? cfg_dec_exp : cfg_enc_exp;
                        if (cfg_modulus < WIDTH'(2)) begin
                            r_acc   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_mm_a     <= WIDTH'(1);
                            r_mm_b     <= i_message_value;
                            r_mm_start <= 1'b1;
                            r_state    <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    if (mm_status.done) begin
                        r_base  <= mm_result;
                        r_acc   <= WIDTH'(1);
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (r_exp == '0) begin
                        r_state <= S_DONE;
                    end else if (r_exp[0]) begin
                        r_mm_a     <= r_acc;
                        r_mm_b     <= r_base;
                        r_mm_start <= 1'b1;
                        r_state    <= S_MACC;
                    end else begin
                        r_mm_a     <= r_base;
                        r_mm_b     <= r_base;
                        r_mm_start <= 1'b1;
                        r_state    <= S_MSQ;
                    end
                end
                S_MACC: begin
                    if (mm_status.done) begin
                        r_acc      <= mm_result;
                        r_mm_a     <= r_base;
                        r_mm_b     <= r_base;
                        r_mm_start <= 1'b1;
                        r_state    <= S_MSQ;
                    end
                end
                S_MSQ: begin
                    if (mm_status.done) begin
                        r_base  <= mm_result;
                        r_exp   <= {1'b0, r_exp[WIDTH-1:1]};
                        r_state <= S_STEP;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_result    <= r_acc;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_result;
    assign pready         = 1'b1;

`include "assert_macros.svh"

    `AST_RUN(a_no_accept_busy, in_acc |-> !mm_status.busy, "word accepted while multiplier busy")
    `AST_RUN(a_done_in_mul, mm_status.done |-> (r_state == S_RED || r_state == S_MACC || r_state == S_MSQ), "multiplier done outside a multiply state")
    `AST_RUN(a_result_below_n, (r_out_valid && r_n >= WIDTH'(2)) |-> (r_result < r_n), "result not reduced below the modulus")
    `AST_ALL(a_reset_clears, !i_rst_n |=> (!o_out_valid && o_in_ready), "reset did not clear the channels")

endmodule

// ===== rtl/rme_cfg.sv =====
// apb register file: modulus and the two exponents
// depends on rme_pkg
module rme_cfg #(
    parameter int WIDTH = 32,
    parameter int PDW   = 32,
    parameter int ASH   = 2,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AW-1:0]    paddr,
    input  logic [PDW-1:0]   pwdata,
    output logic [PDW-1:0]   prdata,
    output logic [WIDTH-1:0] o_modulus,
    output logic [WIDTH-1:0] o_enc_exp,
    output logic [WIDTH-1:0] o_dec_exp
);
    import rme_pkg::*;

    logic [WIDTH-1:0] r_modulus;
    logic [WIDTH-1:0] r_enc_exp;
    logic [WIDTH-1:0] r_dec_exp;
    logic [1:0]       reg_idx;
    logic [WIDTH-1:0] rd_val;
    logic             wr_en;

    assign reg_idx = paddr[ASH+1:ASH];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= WIDTH'(2);
            r_enc_exp <= WIDTH'(1);
            r_dec_exp <= WIDTH'(1);
        end else if (wr_en) begin
            case (reg_idx)
                REG_MODULUS: r_modulus <= pwdata[WIDTH-1:0];
                REG_ENC_EXP: r_enc_exp <= pwdata[WIDTH-1:0];
                REG_DEC_EXP: r_dec_exp <= pwdata[WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MODULUS: rd_val = r_modulus;
            REG_ENC_EXP: rd_val = r_enc_exp;
            REG_DEC_EXP: rd_val = r_dec_exp;
            default:     rd_val = '0;
        endcase
    end

    assign prdata    = PDW'(rd_val);
    assign o_modulus = r_modulus;
    assign o_enc_exp = r_enc_exp;
    assign o_dec_exp = r_dec_exp;

endmodule

// ===== rtl/rme_modmul.sv =====
// serial modular multiplier: one multiplier bit per cycle, msb first
// depends on rme_pkg; operand a must be below n
module rme_modmul #(
    parameter int WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WIDTH-1:0]     i_a,
    input  logic [WIDTH-1:0]     i_b,
    input  logic [WIDTH-1:0]     i_n,
    output rme_pkg::t_mm_status  o_status,
    output logic [WIDTH-1:0]     o_result
);
    import rme_pkg::*;

    localparam int SW = WIDTH + 2;
    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] r_n;
    logic [WIDTH:0]   r_n2;
    logic [WIDTH-1:0] r_acc;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [WIDTH-1:0] addend;
    logic [SW-1:0]    s_sum;
    logic [SW:0]      d1;
    logic [SW:0]      d2;
    logic [WIDTH-1:0] n_acc;

    assign addend = r_b[WIDTH-1] ? r_a : '0;
    assign s_sum  = {1'b0, r_acc, 1'b0} + {2'b00, addend};
    assign d1     = {1'b0, s_sum} - {3'b000, r_n};
    assign d2     = {1'b0, s_sum} - {2'b00, r_n2};

    always_comb begin
        if (!d2[SW]) begin
            n_acc = d2[WIDTH-1:0];
        end else if (!d1[SW]) begin
            n_acc = d1[WIDTH-1:0];
        end else begin
            n_acc = s_sum[WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_n   <= i_n;
            r_n2  <= {i_n, 1'b0};
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[WIDTH-2:0], 1'b0};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_result      = r_acc;

endmodule
